// ===== rtl/fmt_pkg.sv =====
package fmt_pkg;

    localparam int unsigned FLAG_ZERO   = 0;
    localparam int unsigned FLAG_SIGNED = 1;
    localparam int unsigned FLAG_PLUS   = 2;
    localparam int unsigned FLAG_SPACE  = 3;
    localparam int unsigned FLAG_LEFT   = 4;
    localparam int unsigned FLAG_PREFIX = 5;
    localparam int unsigned FLAG_UPPER  = 6;

    localparam logic [5:0] BASE_MIN = 6'd2;
    localparam logic [5:0] BASE_MAX = 6'd36;
    localparam logic [5:0] BASE_OCT = 6'd8;
    localparam logic [5:0] BASE_HEX = 6'd16;

    localparam logic [7:0] CH_ZERO  = 8'h30;
    localparam logic [7:0] CH_SPACE = 8'h20;
    localparam logic [7:0] CH_MINUS = 8'h2d;
    localparam logic [7:0] CH_PLUS  = 8'h2b;
    localparam logic [7:0] CH_X_LO  = 8'h78;
    localparam logic [7:0] CH_X_UP  = 8'h58;

    localparam int unsigned DIV_BITS_PER_CYCLE = 8;

    typedef struct packed {
        logic [63:0] value;
        logic [5:0]  base;
        logic [6:0]  width;
        logic [6:0]  precision;
        logic [6:0]  flags;
    } fmt_in_t;

    typedef struct packed {
        logic [7:0] out_char;
        logic       char_valid;
        logic       last;
        logic       bad_base;
        logic       truncated;
        logic [6:0] full_length;
    } fmt_out_t;

    typedef struct packed {
        logic        bad;
        logic [63:0] mag;
        logic [5:0]  base;
        logic [6:0]  width;
        logic [6:0]  prec;
        logic        has_sign;
        logic [7:0]  sign_ch;
        logic [1:0]  pfx;
        logic        zero;
        logic        left;
        logic        upper;
    } fmt_desc_t;

    function automatic logic [7:0] digit_char(input logic [5:0] d, input logic upper);
        logic [7:0] c;
        begin
            if (d < 6'd10) begin
                c = CH_ZERO + {2'b00, d};
            end else if (upper) begin
                c = 8'h41 + {2'b00, d} - 8'd10;
            end else begin
                c = 8'h61 + {2'b00, d} - 8'd10;
            end
            return c;
        end
    endfunction

endpackage

// ===== rtl/integer_to_text_formatter.sv =====
// channel | ports                    | payload
// input   | s_valid, s_ready, s_data | fmt_in_t: value, base, width, precision, flags
// result  | m_valid, m_ready, m_data | fmt_out_t: at most one character per transfer
//
// Digits are made by long division, 8 quotient bits per cycle, one digit per division.
// A request holds the back end through its divide, setup and emit states until its
// last character is sent. A bad base gives a single result with bad_base set and
// no division. A two-entry queue lets the next request wait while the current
// one is divided or sent. Reset (aresetn, synchronous) empties all.
// m_ready low stalls sending only; the queue keeps taking requests until full.
module integer_to_text_formatter #(
    parameter int unsigned MAX_OUT = 64
) (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              s_valid,
    output logic              s_ready,
    input  fmt_pkg::fmt_in_t  s_data,
    output logic              m_valid,
    input  logic              m_ready,
    output fmt_pkg::fmt_out_t m_data
);
    import fmt_pkg::*;

    fmt_desc_t front_desc, q_desc;
    logic      q_full, q_empty, q_pop;

    fmt_front u_front (
        .item (s_data),
        .desc (front_desc)
    );

    assign s_ready = !q_full;

    fmt_fifo u_fifo (
        .aclk    (aclk),
        .aresetn (aresetn),
        .wr_en   (s_valid && !q_full),
        .wr_data (front_desc),
        .full    (q_full),
        .rd_en   (q_pop),
        .rd_data (q_desc),
        .empty   (q_empty)
    );

    fmt_back #(.MAX_OUT(MAX_OUT)) u_back (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .desc       (q_desc),
        .desc_empty (q_empty),
        .desc_pop   (q_pop),
        .m_valid    (m_valid),
        .m_ready    (m_ready),
        .m_data     (m_data)
    );

    a_bad_single: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_data.bad_base |-> m_data.last && !m_data.char_valid)
        else $error("bad base result malformed");

    a_trunc_len: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_data.truncated |-> m_data.full_length > 7'(MAX_OUT))
        else $error("truncated without overlong field");

    a_pop_nonempty: assert property (@(posedge aclk) disable iff (!aresetn)
        q_pop |-> !q_empty)
        else $error("queue popped while empty");

endmodule

// ===== rtl/fmt_front.sv =====
module fmt_front (
    input  fmt_pkg::fmt_in_t   item,
    output fmt_pkg::fmt_desc_t desc
);
    import fmt_pkg::*;

    logic neg;
    logic left;

    always_comb begin
        left = item.flags[FLAG_LEFT];
        neg  = item.flags[FLAG_SIGNED] & item.value[63];
        desc.bad   = (item.base < BASE_MIN) || (item.base > BASE_MAX);
        desc.mag   = neg ? (64'd0 - item.value) : item.value;
        desc.base  = item.base;
        desc.width = item.width;
        desc.prec  = item.precision;
        desc.has_sign = item.flags[FLAG_SIGNED] &
                        (neg | item.flags[FLAG_PLUS] | item.flags[FLAG_SPACE]);
        desc.sign_ch = neg ? CH_MINUS : (item.flags[FLAG_PLUS] ? CH_PLUS : CH_SPACE);
        if (item.flags[FLAG_PREFIX] && item.base == BASE_HEX) begin
            desc.pfx = 2'd2;
        end else if (item.flags[FLAG_PREFIX] && item.base == BASE_OCT) begin
            desc.pfx = 2'd1;
        end else begin
            desc.pfx = 2'd0;
        end
        desc.zero  = item.flags[FLAG_ZERO] & ~left;
        desc.left  = left;
        desc.upper = item.flags[FLAG_UPPER];
    end

endmodule

// ===== rtl/fmt_fifo.sv =====
module fmt_fifo (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               wr_en,
    input  fmt_pkg::fmt_desc_t wr_data,
    output logic               full,
    input  logic               rd_en,
    output fmt_pkg::fmt_desc_t rd_data,
    output logic               empty
);
    import fmt_pkg::*;

    fmt_desc_t  mem_reg [2];
    logic       wptr_reg, rptr_reg;
    logic [1:0] cnt_reg;

    assign full    = (cnt_reg == 2'd2);
    assign empty   = (cnt_reg == 2'd0);
    assign rd_data = mem_reg[rptr_reg];

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem_reg[wptr_reg] <= wr_data;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wptr_reg <= 1'b0;
            rptr_reg <= 1'b0;
            cnt_reg  <= 2'd0;
        end else begin
            if (wr_en) begin
                wptr_reg <= ~wptr_reg;
            end
            if (rd_en) begin
                rptr_reg <= ~rptr_reg;
            end
            cnt_reg <= cnt_reg + {1'b0, wr_en} - {1'b0, rd_en};
        end
    end

endmodule

// ===== rtl/fmt_back.sv =====
module fmt_back #(
    parameter int unsigned MAX_OUT = 64
) (
    input  logic               aclk,
    input  logic               aresetn,
    input  fmt_pkg::fmt_desc_t desc,
    input  logic               desc_empty,
    output logic               desc_pop,
    output logic               m_valid,
    input  logic               m_ready,
    output fmt_pkg::fmt_out_t  m_data
);
    import fmt_pkg::*;

    typedef enum logic [1:0] {B_IDLE, B_DIV, B_SETUP, B_EMIT} state_t;

    state_t     st_reg;
    fmt_desc_t  d_reg;
    logic [63:0] w_reg;
    logic [5:0]  rem_reg;
    logic [2:0]  step_reg;
    logic [5:0]  dig_reg [64];
    logic [6:0]  nd_reg;
    logic [7:0]  b1_reg, b2_reg, b3_reg, b5_reg, b6_reg;
    logic [7:0]  emit_reg, cnt_reg;
    logic        trunc_reg;
    logic [6:0]  full_reg;
    logic        m_valid_reg;
    fmt_out_t    m_data_reg;

    logic [63:0] w_next;
    logic [5:0]  rem_next;
    logic [6:0]  t;
    logic        out_free;
    logic        send_bad, send_ch;

    logic [6:0] prec_eff;
    logic [7:0] core, len, pad8, lead, zf, b1, b2, b3, b4, b5, b6;
    logic [7:0] ch;
    logic       in_digits;

    assign out_free = !m_valid_reg || m_ready;
    assign m_valid  = m_valid_reg;
    assign m_data   = m_data_reg;
    assign desc_pop = (st_reg == B_IDLE) && !desc_empty && (!desc.bad || out_free);
    assign send_bad = (st_reg == B_IDLE) && !desc_empty && desc.bad && out_free;
    assign send_ch  = (st_reg == B_EMIT) && out_free;

    always_comb begin
        w_next   = w_reg;
        rem_next = rem_reg;
        for (int i = 0; i < DIV_BITS_PER_CYCLE; i++) begin
            t      = {rem_next, w_next[63]};
            w_next = {w_next[62:0], 1'b0};
            if (t >= {1'b0, d_reg.base}) begin
                t         = t - {1'b0, d_reg.base};
                w_next[0] = 1'b1;
            end
            rem_next = t[5:0];
        end
    end

    always_comb begin
        prec_eff = (d_reg.prec < nd_reg) ? nd_reg : d_reg.prec;
        core = {7'd0, d_reg.has_sign} + {6'd0, d_reg.pfx} + {1'b0, prec_eff};
        pad8 = ({1'b0, d_reg.width} > core) ? ({1'b0, d_reg.width} - core) : 8'd0;
        len  = core + pad8;
        lead = (!d_reg.zero && !d_reg.left) ? pad8 : 8'd0;
        zf   = d_reg.zero ? pad8 : 8'd0;
        b1 = lead;
        b2 = b1 + {7'd0, d_reg.has_sign};
        b3 = b2 + {6'd0, d_reg.pfx};
        b4 = b3 + zf;
        b5 = b4 + {1'b0, prec_eff - nd_reg};
        b6 = b5 + {1'b0, nd_reg};
    end

    always_comb begin
        in_digits = 1'b0;
        if (cnt_reg < b1_reg) begin
            ch = CH_SPACE;
        end else if (cnt_reg < b2_reg) begin
            ch = d_reg.sign_ch;
        end else if (cnt_reg < b3_reg) begin
            ch = (cnt_reg == b2_reg) ? CH_ZERO : (d_reg.upper ? CH_X_UP : CH_X_LO);
        end else if (cnt_reg < b5_reg) begin
            ch = CH_ZERO;
        end else if (cnt_reg < b6_reg) begin
            ch = digit_char(dig_reg[0], d_reg.upper);
            in_digits = 1'b1;
        end else begin
            ch = CH_SPACE;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            st_reg      <= B_IDLE;
            m_valid_reg <= 1'b0;
        end else begin
            if (send_bad || send_ch) begin
                m_valid_reg <= 1'b1;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
            case (st_reg)
                B_IDLE: begin
                    if (!desc_empty) begin
                        if (desc.bad) begin
                            if (out_free) begin
                                m_data_reg  <= '{out_char: 8'd0, char_valid: 1'b0,
                                                 last: 1'b1, bad_base: 1'b1,
                                                 truncated: 1'b0, full_length: 7'd0};
                            end
                        end else begin
                            d_reg    <= desc;
                            w_reg    <= desc.mag;
                            rem_reg  <= 6'd0;
                            step_reg <= 3'd0;
                            nd_reg   <= 7'd0;
                            st_reg   <= B_DIV;
                        end
                    end
                end
                B_DIV: begin
                    step_reg <= step_reg + 3'd1;
                    if (step_reg == 3'(DIV_BITS_PER_CYCLE - 1)) begin
                        for (int i = 63; i > 0; i--) begin
                            dig_reg[i] <= dig_reg[i-1];
                        end
                        dig_reg[0] <= rem_next;
                        nd_reg     <= nd_reg + 7'd1;
                        w_reg      <= w_next;
                        rem_reg    <= 6'd0;
                        if (w_next == 64'd0) begin
                            st_reg <= B_SETUP;
                        end
                    end else begin
                        w_reg   <= w_next;
                        rem_reg <= rem_next;
                    end
                end
                B_SETUP: begin
                    b1_reg    <= b1;
                    b2_reg    <= b2;
                    b3_reg    <= b3;
                    b5_reg    <= b5;
                    b6_reg    <= b6;
                    emit_reg  <= (len > 8'(MAX_OUT)) ? 8'(MAX_OUT) : len;
                    trunc_reg <= len > 8'(MAX_OUT);
                    full_reg  <= (len > 8'd127) ? 7'd127 : len[6:0];
                    cnt_reg   <= 8'd0;
                    st_reg    <= B_EMIT;
                end
                B_EMIT: begin
                    if (out_free) begin
                        m_data_reg  <= '{out_char: ch, char_valid: 1'b1,
                                         last: (cnt_reg == emit_reg - 8'd1),
                                         bad_base: 1'b0, truncated: trunc_reg,
                                         full_length: full_reg};
                        cnt_reg <= cnt_reg + 8'd1;
                        if (in_digits) begin
                            for (int i = 0; i < 63; i++) begin
                                dig_reg[i] <= dig_reg[i+1];
                            end
                        end
                        if (cnt_reg == emit_reg - 8'd1) begin
                            st_reg <= B_IDLE;
                        end
                    end
                end
                default: st_reg <= B_IDLE;
            endcase
        end
    end

endmodule
